### rtl/cvh_pkg.sv
// Shared types and codes for the Graham scan convex hull block.
`timescale 1ns / 1ps
package cvh_pkg;

    localparam int OP_BITS = 4;

    localparam logic [OP_BITS-1:0] OP_NONE      = 4'd0;
    localparam logic [OP_BITS-1:0] OP_LOAD      = 4'd1;
    localparam logic [OP_BITS-1:0] OP_PIV_CLEAR = 4'd2;
    localparam logic [OP_BITS-1:0] OP_PIV_STEP  = 4'd3;
    localparam logic [OP_BITS-1:0] OP_PIV_SWAP  = 4'd4;
    localparam logic [OP_BITS-1:0] OP_SORT_CMP  = 4'd5;
    localparam logic [OP_BITS-1:0] OP_SORT_SWAP = 4'd6;
    localparam logic [OP_BITS-1:0] OP_FETCH     = 4'd7;
    localparam logic [OP_BITS-1:0] OP_SCAN_INIT = 4'd8;
    localparam logic [OP_BITS-1:0] OP_TURN      = 4'd9;
    localparam logic [OP_BITS-1:0] OP_PUSH      = 4'd10;
    localparam logic [OP_BITS-1:0] OP_POP       = 4'd11;
    localparam logic [OP_BITS-1:0] OP_EMIT      = 4'd12;
    localparam logic [OP_BITS-1:0] OP_CLEAR     = 4'd13;
    localparam logic [OP_BITS-1:0] OP_MUL       = 4'd14;

    typedef struct packed {
        logic [OP_BITS-1:0] op;
        logic               sel_a;
    } cvh_cmd_t;

    typedef struct packed {
        logic small_set;
        logic flag;
        logic done;
    } cvh_stat_t;

endpackage

### rtl/convex_hull_graham_scan.sv
// Top level of the Graham scan convex hull block.
// Points load one request per cycle; after the last, n points go through the pivot search, the
// sort compares (up to (n-1)*(n-2)/2 of them), the scan pushes or pops, then one vertex per cycle;
// small sets (n <= 3) skip to output. Results appear on strobe; the receiver cannot stall them.
// busy stays high from the last point until the final vertex has been shown.
// rst_n is asynchronous and clears all control state; stored points are not cleared.
`timescale 1ns / 1ps
module convex_hull_graham_scan
    import cvh_pkg::*;
#(
    parameter int MAX_POINTS = 32,
    parameter int COORD_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_BITS-1:0] in_x,
    input  logic [COORD_BITS-1:0] in_y,
    input  logic                  in_last,
    output logic                  strobe,
    output logic [COORD_BITS-1:0] hull_x,
    output logic [COORD_BITS-1:0] hull_y,
    output logic                  hull_last,
    output logic                  overflowed
);

    cvh_cmd_t  cmd;
    cvh_stat_t stat;

    cvh_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .in_last (in_last),
        .busy    (busy),
        .strobe  (strobe),
        .cmd     (cmd),
        .stat    (stat)
    );

    cvh_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_x       (in_x),
        .in_y       (in_y),
        .stat       (stat),
        .hull_x     (hull_x),
        .hull_y     (hull_y),
        .hull_last  (hull_last),
        .overflowed (overflowed),
        .drop_in    (1'b0)
    );

endmodule

### rtl/cvh_datapath.sv
// Datapath: point store, sort and scan index registers, cross product unit, hull stack.
`timescale 1ns / 1ps
module cvh_datapath
    import cvh_pkg::*;
#(
    parameter int MAX_POINTS = 32,
    parameter int COORD_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cvh_cmd_t              cmd,
    input  logic [COORD_BITS-1:0] in_x,
    input  logic [COORD_BITS-1:0] in_y,
    output cvh_stat_t             stat,
    output logic [COORD_BITS-1:0] hull_x,
    output logic [COORD_BITS-1:0] hull_y,
    output logic                  hull_last,
    output logic                  overflowed,
    input  logic                  drop_in
);

    localparam int IW = $clog2(MAX_POINTS + 2);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;

    logic [2*COORD_BITS-1:0] mem [MAX_POINTS];
    // stack entries 1 and up; entry 0 is always the last sorted point
    logic [AW-1:0]           hstk [MAX_POINTS];

    logic [IW-1:0] count_reg, count_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] j_reg, j_next;
    logic [IW-1:0] sp_reg, sp_next;
    logic [AW-1:0] piv_reg, piv_next;
    logic          drop_reg, drop_next;
    logic          flag_reg, flag_next;
    logic [IW-1:0] k_reg, k_next;
    logic [1:0]    ph_reg, ph_next;

    logic [2*COORD_BITS-1:0] pa_reg, pb_reg, pc_reg, pp_reg;
    logic [2*COORD_BITS-1:0] rd_reg;
    logic [AW-1:0]           ra_reg, rb_reg;
    logic signed [PW-1:0]    m1_reg, m2_reg;
    logic signed [SW-1:0]    cr_reg;
    logic [SW-1:0]           d1_reg;

    logic signed [COORD_BITS-1:0] ax, ay, bx, by, cx, cy;
    logic signed [DW-1:0] ux, uy, vx, vy;
    logic signed [PW-1:0] p1, p2;

    assign ax = pa_reg[2*COORD_BITS-1:COORD_BITS];
    assign ay = pa_reg[COORD_BITS-1:0];
    assign bx = pb_reg[2*COORD_BITS-1:COORD_BITS];
    assign by = pb_reg[COORD_BITS-1:0];
    assign cx = pc_reg[2*COORD_BITS-1:COORD_BITS];
    assign cy = pc_reg[COORD_BITS-1:0];

    // ph 0: cross ux*vy, uy*vx; ph 1: dist2 of b; ph 2: dist2 of c (b-a, c-a, a is the pivot when sorting)
    always_comb
    begin
        ux = DW'(bx) - DW'(ax);
        uy = DW'(by) - DW'(ay);
        vx = DW'(cx) - DW'(ax);
        vy = DW'(cy) - DW'(ay);
        unique case (ph_reg)
            2'd0:    begin p1 = ux * vy; p2 = uy * vx; end
            2'd1:    begin p1 = ux * ux; p2 = uy * uy; end
            default: begin p1 = vx * vx; p2 = vy * vy; end
        endcase
    end

    logic signed [COORD_BITS-1:0] rx, ry, px, py;
    assign rx = rd_reg[2*COORD_BITS-1:COORD_BITS];
    assign ry = rd_reg[COORD_BITS-1:0];
    assign px = pp_reg[2*COORD_BITS-1:COORD_BITS];
    assign py = pp_reg[COORD_BITS-1:0];

    logic [AW-1:0] top_idx, sec_idx, out_idx;
    assign top_idx = (sp_reg <= IW'(1)) ? AW'(count_reg - IW'(1))
                                        : hstk[AW'(sp_reg - IW'(2))];
    assign sec_idx = (sp_reg <= IW'(2)) ? AW'(count_reg - IW'(1))
                                        : hstk[AW'(sp_reg - IW'(3))];
    assign out_idx = (k_reg == '0) ? AW'(count_reg - IW'(1))
                                   : hstk[AW'(k_reg - IW'(1))];

    always_comb
    begin
        count_next = count_reg;
        i_next = i_reg;
        j_next = j_reg;
        sp_next = sp_reg;
        piv_next = piv_reg;
        drop_next = drop_reg;
        flag_next = flag_reg;
        k_next = k_reg;
        ph_next = ph_reg;
        unique case (cmd.op)
            OP_LOAD:
            begin
                if (count_reg < IW'(MAX_POINTS))
                    count_next = count_reg + IW'(1);
                else
                    drop_next = 1'b1;
                if (drop_in)
                    drop_next = 1'b1;
            end
            OP_PIV_CLEAR:
            begin
                piv_next = '0;
                i_next = IW'(1);
                k_next = '0;
            end
            OP_PIV_STEP:
            begin
                if (ry < py || (ry == py && rx > px))
                    piv_next = AW'(i_reg);
                i_next = i_reg + IW'(1);
            end
            OP_PIV_SWAP:
            begin
                i_next = IW'(2);
                j_next = IW'(2);
            end
            OP_FETCH:
            begin
                ph_next = 2'd0;
            end
            OP_MUL:
            begin
                ph_next = ph_reg + 2'd1;
            end
            OP_SORT_CMP:
            begin
                flag_next = (cr_reg != '0) ? (cr_reg > 0) : (d1_reg < SW'(m1_reg + m2_reg));
            end
            OP_SORT_SWAP:
            begin
                if (cmd.sel_a)
                begin
                    j_next = j_reg - IW'(1);
                end
                else
                begin
                    i_next = i_reg + IW'(1);
                    j_next = i_reg + IW'(1);
                end
            end
            OP_SCAN_INIT:
            begin
                sp_next = IW'(3);
                i_next = IW'(2);
            end
            OP_TURN:
            begin
                flag_next = (sp_reg <= IW'(2)) || (cr_reg > 0);
            end
            OP_PUSH:
            begin
                if (sp_reg < IW'(MAX_POINTS + 1))
                    sp_next = sp_reg + IW'(1);
                i_next = i_reg + IW'(1);
            end
            OP_POP:
            begin
                sp_next = sp_reg - IW'(1);
            end
            OP_EMIT:
            begin
                k_next = k_reg + IW'(1);
            end
            OP_CLEAR:
            begin
                count_next = '0;
                sp_next = '0;
                drop_next = 1'b0;
                k_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
            sp_reg <= '0;
            piv_reg <= '0;
            drop_reg <= 1'b0;
            flag_reg <= 1'b0;
            k_reg <= '0;
            ph_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            i_reg <= i_next;
            j_reg <= j_next;
            sp_reg <= sp_next;
            piv_reg <= piv_next;
            drop_reg <= drop_next;
            flag_reg <= flag_next;
            k_reg <= k_next;
            ph_reg <= ph_next;
        end
    end

    // Point store and operand registers; reads are registered.
    always_ff @(posedge clk)
    begin
        m1_reg <= p1;
        m2_reg <= p2;
        if (cmd.op == OP_MUL && ph_reg == 2'd0)
            cr_reg <= SW'(m1_reg) - SW'(m2_reg);
        if (cmd.op == OP_MUL && ph_reg == 2'd2)
            d1_reg <= SW'(m1_reg + m2_reg);
        unique case (cmd.op)
            OP_LOAD:
            begin
                if (count_reg < IW'(MAX_POINTS))
                    mem[AW'(count_reg)] <= {in_x, in_y};
            end
            OP_PIV_CLEAR:
            begin
                pp_reg <= mem[0];
                rd_reg <= mem[AW'(IW'(1))];
            end
            OP_PIV_STEP:
            begin
                if (ry < py || (ry == py && rx > px))
                    pp_reg <= rd_reg;
                rd_reg <= mem[AW'(i_next)];
            end
            OP_PIV_SWAP:
            begin
                // one write per cycle: pivot slot gets slot 0, slot 0 gets the pivot
                if (cmd.sel_a)
                    mem[0] <= pp_reg;
                else
                begin
                    mem[piv_reg] <= mem[0];
                end
            end
            OP_FETCH:
            begin
                if (cmd.sel_a)
                begin
                    pa_reg <= mem[sec_idx];
                    pb_reg <= mem[top_idx];
                    pc_reg <= mem[AW'(i_reg)];
                end
                else
                begin
                    pa_reg <= mem[0];
                    pb_reg <= mem[AW'(j_reg)];
                    pc_reg <= mem[AW'(j_reg - IW'(1))];
                    ra_reg <= AW'(j_reg);
                    rb_reg <= AW'(j_reg - IW'(1));
                end
            end
            OP_SORT_SWAP:
            begin
                if (cmd.sel_a)
                begin
                    mem[ra_reg] <= pc_reg;
                    mem[rb_reg] <= pb_reg;
                end
            end
            OP_SCAN_INIT:
            begin
                hstk[0] <= '0;
                hstk[1] <= AW'(IW'(1));
            end
            OP_PUSH:
            begin
                if (sp_reg < IW'(MAX_POINTS + 1))
                    hstk[AW'(sp_reg - IW'(1))] <= AW'(i_reg);
            end
            OP_EMIT:
            begin
                if (stat.small_set)
                    rd_reg <= mem[AW'(k_reg)];
                else
                    rd_reg <= mem[out_idx];
            end
            default:
            begin
            end
        endcase
    end

    logic          emit_d_reg;
    logic          last_d_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_d_reg <= 1'b0;
            last_d_reg <= 1'b0;
        end
        else
        begin
            emit_d_reg <= (cmd.op == OP_EMIT);
            last_d_reg <= (k_reg + IW'(1) == (stat.small_set ? count_reg : sp_reg));
        end
    end

    assign hull_x = rd_reg[2*COORD_BITS-1:COORD_BITS];
    assign hull_y = rd_reg[COORD_BITS-1:0];
    assign hull_last = emit_d_reg & last_d_reg;
    assign overflowed = drop_reg;

    always_comb
    begin
        stat.small_set = (count_reg <= IW'(3));
        stat.flag = flag_reg;
        priority if (cmd.op == OP_PIV_STEP)
            stat.done = (i_reg + IW'(1) >= count_reg);
        else if (cmd.op == OP_SORT_CMP)
            stat.done = 1'b0;
        else if (cmd.op == OP_SORT_SWAP)
            stat.done = (i_reg + IW'(1) >= count_reg);
        else if (cmd.op == OP_PUSH)
            stat.done = (i_reg + IW'(1) >= count_reg);
        else if (cmd.op == OP_EMIT)
            stat.done = (k_reg + IW'(1) == (stat.small_set ? count_reg : sp_reg));
        else
            stat.done = (j_reg <= IW'(1));
    end

endmodule

### rtl/cvh_ctrl.sv
// Controller state machine sequencing load, pivot search, insertion sort, scan and output.
`timescale 1ns / 1ps
module cvh_ctrl
    import cvh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      in_last,
    output logic      busy,
    output logic      strobe,
    output cvh_cmd_t  cmd,
    input  cvh_stat_t stat
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_PIVC   = 5'd1;
    localparam logic [4:0] S_PIVS   = 5'd2;
    localparam logic [4:0] S_SWA    = 5'd3;
    localparam logic [4:0] S_SWB    = 5'd4;
    localparam logic [4:0] S_SF     = 5'd5;
    localparam logic [4:0] S_SM0    = 5'd6;
    localparam logic [4:0] S_SM1    = 5'd7;
    localparam logic [4:0] S_SM2    = 5'd8;
    localparam logic [4:0] S_SM3    = 5'd9;
    localparam logic [4:0] S_SC     = 5'd10;
    localparam logic [4:0] S_SX     = 5'd11;
    localparam logic [4:0] S_INIT   = 5'd12;
    localparam logic [4:0] S_TF     = 5'd13;
    localparam logic [4:0] S_TM0    = 5'd14;
    localparam logic [4:0] S_TM1    = 5'd15;
    localparam logic [4:0] S_TC     = 5'd16;
    localparam logic [4:0] S_TD     = 5'd17;
    localparam logic [4:0] S_EMIT   = 5'd18;
    localparam logic [4:0] S_CLR    = 5'd19;
    localparam logic [4:0] S_SNEXT  = 5'd20;
    localparam logic [4:0] S_PIVW   = 5'd21;
    localparam logic [4:0] S_SADV   = 5'd22;

    logic [4:0] state_reg, state_next;
    logic       emit_d_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd.op = OP_NONE;
        cmd.sel_a = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op = OP_LOAD;
                    if (in_last)
                        state_next = S_PIVW;
                end
            end
            S_PIVW:  state_next = stat.small_set ? S_EMIT : S_PIVC;
            S_PIVC:
            begin
                cmd.op = OP_PIV_CLEAR;
                state_next = S_PIVS;
            end
            S_PIVS:
            begin
                cmd.op = OP_PIV_STEP;
                if (stat.done)
                    state_next = S_SWA;
            end
            S_SWA:
            begin
                cmd.op = OP_PIV_SWAP;
                state_next = S_SWB;
            end
            S_SWB:
            begin
                cmd.op = OP_PIV_SWAP;
                cmd.sel_a = 1'b1;
                state_next = S_SF;
            end
            S_SF:
            begin
                cmd.op = OP_FETCH;
                state_next = S_SM0;
            end
            S_SM0:   state_next = S_SM1;
            S_SM1:
            begin
                cmd.op = OP_MUL;
                state_next = S_SM2;
            end
            S_SM2:
            begin
                cmd.op = OP_MUL;
                state_next = S_SM3;
            end
            S_SM3:
            begin
                cmd.op = OP_MUL;
                state_next = S_SC;
            end
            S_SC:
            begin
                cmd.op = OP_SORT_CMP;
                state_next = S_SX;
            end
            S_SX:
            begin
                cmd.op = OP_SORT_SWAP;
                cmd.sel_a = stat.flag;
                state_next = S_SNEXT;
                if (!stat.flag && stat.done)
                    state_next = S_INIT;
            end
            S_SNEXT:
            begin
                // inner loop ends when j reaches 1
                state_next = stat.done ? S_SADV : S_SF;
            end
            S_SADV:
            begin
                cmd.op = OP_SORT_SWAP;
                state_next = stat.done ? S_INIT : S_SF;
            end
            S_INIT:
            begin
                cmd.op = OP_SCAN_INIT;
                state_next = S_TF;
            end
            S_TF:
            begin
                cmd.op = OP_FETCH;
                cmd.sel_a = 1'b1;
                state_next = S_TM0;
            end
            S_TM0:   state_next = S_TM1;
            S_TM1:
            begin
                cmd.op = OP_MUL;
                state_next = S_TC;
            end
            S_TC:
            begin
                cmd.op = OP_TURN;
                state_next = S_TD;
            end
            S_TD:
            begin
                if (stat.flag)
                begin
                    cmd.op = OP_PUSH;
                    state_next = stat.done ? S_EMIT : S_TF;
                end
                else
                begin
                    cmd.op = OP_POP;
                    state_next = S_TF;
                end
            end
            S_EMIT:
            begin
                cmd.op = OP_EMIT;
                if (stat.done)
                    state_next = S_CLR;
            end
            S_CLR:
            begin
                cmd.op = OP_CLEAR;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            emit_d_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            emit_d_reg <= (cmd.op == OP_EMIT);
        end
    end

    assign busy = (state_reg != S_IDLE) || emit_d_reg;
    assign strobe = emit_d_reg;

endmodule

### tb/testbench.sv
// Testbench for the Graham scan convex hull block: directed and randomized point sets checked against a predictor.
`timescale 1ns / 1ps
module testbench;
    import cvh_pkg::*;

    localparam int MAXP = 32;
    localparam int CB = 16;
    localparam int WATCH_LIMIT = 40000;

    typedef struct {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic                 last;
    } point_req_t;

    typedef struct {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic          last;
        logic          ovf;
    } vertex_t;

    logic clk, rst_n, start, in_last;
    logic [CB-1:0] in_x, in_y;
    logic busy, strobe, hull_last, overflowed;
    logic [CB-1:0] hull_x, hull_y;

    convex_hull_graham_scan #(.MAX_POINTS(MAXP), .COORD_BITS(CB)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .in_x(in_x), .in_y(in_y), .in_last(in_last),
        .strobe(strobe), .hull_x(hull_x), .hull_y(hull_y),
        .hull_last(hull_last), .overflowed(overflowed)
    );

    point_req_t request_q[$];
    vertex_t    vertex_q[$];
    int         errors = 0;

    // predictor state
    longint pts_x[MAXP];
    longint pts_y[MAXP];
    int     pts_n = 0;
    bit     dropped = 0;
    int     stk[MAXP+1];
    int     depth;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic longint cross3(int a, int b, int c);
        return (pts_x[b] - pts_x[a]) * (pts_y[c] - pts_y[a])
             - (pts_y[b] - pts_y[a]) * (pts_x[c] - pts_x[a]);
    endfunction

    function automatic longint dist_sq(int a);
        longint dx, dy;
        dx = pts_x[a] - pts_x[0];
        dy = pts_y[a] - pts_y[0];
        return dx * dx + dy * dy;
    endfunction

    function automatic void swap_pts(int a, int b);
        longint tx, ty;
        tx = pts_x[a];
        ty = pts_y[a];
        pts_x[a] = pts_x[b];
        pts_y[a] = pts_y[b];
        pts_x[b] = tx;
        pts_y[b] = ty;
    endfunction

    function automatic bit angle_less(int a, int b);
        longint c;
        c = cross3(0, a, b);
        if (c != 0)
            return c > 0;
        return dist_sq(a) < dist_sq(b);
    endfunction

    function automatic void push_vertex(int idx, bit last);
        vertex_t v;
        v.x = pts_x[idx][CB-1:0];
        v.y = pts_y[idx][CB-1:0];
        v.last = last;
        v.ovf = dropped;
        vertex_q = {vertex_q, v};
    endfunction

    function automatic void hull_accept(point_req_t r);
        int n, piv, i, j, t;
        if (pts_n < MAXP)
        begin
            pts_x[pts_n] = longint'(r.x);
            pts_y[pts_n] = longint'(r.y);
            pts_n++;
        end
        else
            dropped = 1;
        if (!r.last)
            return;
        n = pts_n;
        if (n <= 3)
        begin
            for (i = 0; i < n; i++)
                push_vertex(i, i + 1 == n);
        end
        else
        begin
            piv = 0;
            for (i = 1; i < n; i++)
                if (pts_y[i] < pts_y[piv] || (pts_y[i] == pts_y[piv] && pts_x[i] > pts_x[piv]))
                    piv = i;
            swap_pts(0, piv);
            for (i = 2; i < n; i++)
                for (j = i; j > 1 && angle_less(j, j - 1); j--)
                    swap_pts(j, j - 1);
            stk[0] = n - 1;
            stk[1] = 0;
            stk[2] = 1;
            depth = 3;
            i = 2;
            while (i < n)
            begin
                t = depth - 1;
                if (depth <= 2 || cross3(stk[t-1], stk[t], i) > 0)
                begin
                    if (depth < MAXP + 1)
                    begin
                        stk[depth] = i;
                        depth++;
                    end
                    i++;
                end
                else
                    depth--;
            end
            for (i = 0; i < depth; i++)
                push_vertex(stk[i], i + 1 == depth);
        end
        pts_n = 0;
        dropped = 0;
    endfunction

    task automatic report(string what, logic [CB-1:0] got, logic [CB-1:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        errors++;
    endtask

    // driver
    point_req_t cur;
    int         gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 0;
            in_x <= '0;
            in_y <= '0;
            in_last <= 0;
            gap_left <= 0;
        end
        else if (start && !busy)
        begin
            int gap;
            hull_accept(cur);
            gap = $urandom_range(0, 19);
            if (gap == 0 && request_q.size() > 0)
            begin
                cur = request_q.pop_front();
                in_x <= cur.x;
                in_y <= cur.y;
                in_last <= cur.last;
            end
            else
            begin
                start <= 0;
                gap_left <= gap;
            end
        end
        else if (!start)
        begin
            if (gap_left > 0)
                gap_left <= gap_left - 1;
            else if (request_q.size() > 0)
            begin
                cur = request_q.pop_front();
                in_x <= cur.x;
                in_y <= cur.y;
                in_last <= cur.last;
                start <= 1;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (vertex_q.size() == 0)
            begin
                $display("%0t unexpected vertex %h,%h", $realtime, hull_x, hull_y);
                errors++;
            end
            else
            begin
                vertex_t e;
                e = vertex_q.pop_front();
                if (hull_x !== e.x) report("hull_x", hull_x, e.x);
                if (hull_y !== e.y) report("hull_y", hull_y, e.y);
                if (hull_last !== e.last) report("hull_last", hull_last, e.last);
                if (overflowed !== e.ovf) report("overflowed", overflowed, e.ovf);
            end
        end
    end

    // watchdog
    int quiet;
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            quiet <= 0;
        else
        begin
            quiet <= quiet + 1;
            if (quiet >= WATCH_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic add_point(int x, int y, bit last);
        point_req_t r;
        r.x = x[CB-1:0];
        r.y = y[CB-1:0];
        r.last = last;
        request_q = {request_q, r};
    endtask

    task automatic add_set(int n, int span);
        int i, x, y;
        for (i = 0; i < n; i++)
        begin
            if (span == 0)
            begin
                x = $urandom_range(0, 65535) - 32768;
                y = $urandom_range(0, 65535) - 32768;
            end
            else
            begin
                x = $urandom_range(0, 2 * span) - span;
                y = $urandom_range(0, 2 * span) - span;
            end
            add_point(x, y, i == n - 1);
        end
    endtask

    initial
    begin
        int total, n;
        rst_n = 0;
        // single extreme point, two points, three points
        add_point(-32768, 32767, 1);
        add_point(32767, -32768, 0);
        add_point(-1, 0, 1);
        add_point(5, 5, 0);
        add_point(-32768, -32768, 0);
        add_point(32767, 32767, 1);
        // square with interior point and collinear edge point
        add_point(0, 0, 0);
        add_point(10, 0, 0);
        add_point(10, 10, 0);
        add_point(5, 5, 0);
        add_point(0, 10, 0);
        add_point(5, 0, 1);
        // duplicates, pivot copies, tied lowest y
        add_point(3, -4, 0);
        add_point(3, -4, 0);
        add_point(-2, -4, 0);
        add_point(0, 6, 0);
        add_point(0, 6, 1);
        // all collinear
        add_point(1, 1, 0);
        add_point(3, 3, 0);
        add_point(2, 2, 0);
        add_point(-32768, -32768, 1);
        total = request_q.size();
        while (total < 430)
        begin
            case ($urandom_range(0, 9))
                0: n = $urandom_range(33, 36);
                1: n = $urandom_range(1, 3);
                2: n = $urandom_range(20, 32);
                default: n = $urandom_range(4, 12);
            endcase
            case ($urandom_range(0, 2))
                0: add_set(n, 0);
                1: add_set(n, 3);
                default: add_set(n, 1000);
            endcase
            total += n;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1;
        wait (request_q.size() == 0 && !start && vertex_q.size() == 0);
        repeat (100) @(posedge clk);
        if (errors == 0 && vertex_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
